// File: hw/rtl/tbg_pkg.sv
`timescale 1ns / 1ps

package tbg_pkg;

  // Command codes of one request.
  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_CLEAR_BOX = 2'd1,
    CMD_CLEAR_ALL = 2'd2,
    CMD_LOOKUP    = 2'd3
  } cmd_t;

  // One request on the input channel.
  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] cell_z;
    logic [31:0]        handle_value;
    logic [7:0]         box_x;
    logic [7:0]         box_y;
    logic [7:0]         box_z;
  } in_req_t;

  // One result on the output channel.
  typedef struct packed {
    logic [31:0] found_handle;
    logic        inside_window;
  } out_res_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP
  } state_t;

  // Status of the clearing sweep, seen by the controller.
  typedef struct packed {
    logic busy;
    logic last;
  } sweep_stat_t;

  localparam int EXT_W  = 5;
  localparam int CFG_AW = 5;

  // Register indexes (byte address bits [4:2]).
  localparam logic [2:0] REG_WIN_MIN_X = 3'd0;
  localparam logic [2:0] REG_WIN_MIN_Y = 3'd1;
  localparam logic [2:0] REG_WIN_MIN_Z = 3'd2;
  localparam logic [2:0] REG_WIN_EXT_X = 3'd3;
  localparam logic [2:0] REG_WIN_EXT_Y = 3'd4;
  localparam logic [2:0] REG_WIN_EXT_Z = 3'd5;
  localparam logic [2:0] REG_EMPTY     = 3'd6;

  localparam logic [31:0] EMPTY_RESET = 32'hFFFF_FFFF;

endpackage

// File: hw/rtl/tbg_ram.sv
`timescale 1ns / 1ps

module tbg_ram import tbg_pkg::*; #(
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata_r
);

  logic [31:0] mem [DEPTH];

  // Single port: write on we, registered read of the addressed slot every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

// File: hw/rtl/tbg_addr_gen.sv
`timescale 1ns / 1ps

module tbg_addr_gen import tbg_pkg::*; #(
  parameter int DIM_X = 16,
  parameter int DIM_Y = 16,
  parameter int DIM_Z = 16,
  localparam int XB  = $clog2(DIM_X),
  localparam int YB  = $clog2(DIM_Y),
  localparam int ZB  = $clog2(DIM_Z),
  localparam int XW  = (XB > 0) ? XB : 1,
  localparam int YW  = (YB > 0) ? YB : 1,
  localparam int ZW  = (ZB > 0) ? ZB : 1,
  localparam int LXW = $clog2(DIM_X + 1),
  localparam int LYW = $clog2(DIM_Y + 1),
  localparam int LZW = $clog2(DIM_Z + 1),
  localparam int AW  = ((XB + YB + ZB) > 0) ? (XB + YB + ZB) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [XW-1:0]  crd_x,
  input  logic [YW-1:0]  crd_y,
  input  logic [ZW-1:0]  crd_z,
  input  logic [LXW-1:0] len_x,
  input  logic [LYW-1:0] len_y,
  input  logic [LZW-1:0] len_z,
  output sweep_stat_t    stat,
  output logic [AW-1:0]  addr
);

  localparam logic [XW-1:0] MASK_X = XW'(DIM_X - 1);
  localparam logic [YW-1:0] MASK_Y = YW'(DIM_Y - 1);
  localparam logic [ZW-1:0] MASK_Z = ZW'(DIM_Z - 1);

  logic           busy_r, busy_nxt;
  logic [XW-1:0]  cnt_x_r, cnt_x_nxt;
  logic [YW-1:0]  cnt_y_r, cnt_y_nxt;
  logic [ZW-1:0]  cnt_z_r, cnt_z_nxt;
  logic [XW-1:0]  org_x_r;
  logic [YW-1:0]  org_y_r;
  logic [ZW-1:0]  org_z_r;
  logic [LXW-1:0] len_x_r;
  logic [LYW-1:0] len_y_r;
  logic [LZW-1:0] len_z_r;
  logic           x_last, y_last, z_last;
  logic [XW-1:0]  px;
  logic [YW-1:0]  py;
  logic [ZW-1:0]  pz;

  // Last position on each axis of the box.
  assign x_last = (LXW'(cnt_x_r) + LXW'(1)) == len_x_r;
  assign y_last = (LYW'(cnt_y_r) + LYW'(1)) == len_y_r;
  assign z_last = (LZW'(cnt_z_r) + LZW'(1)) == len_z_r;

  assign stat.busy = busy_r;
  assign stat.last = busy_r && x_last && y_last && z_last;

  // Slot coordinates: sweep origin plus offset, or the direct cell, wrapped.
  always_comb begin
    if (busy_r) begin
      px = (org_x_r + cnt_x_r) & MASK_X;
      py = (org_y_r + cnt_y_r) & MASK_Y;
      pz = (org_z_r + cnt_z_r) & MASK_Z;
    end else begin
      px = crd_x & MASK_X;
      py = crd_y & MASK_Y;
      pz = crd_z & MASK_Z;
    end
    addr = (AW'(pz) << (XB + YB)) | (AW'(py) << XB) | AW'(px);
  end

  // Step x fastest, then y, then z.
  always_comb begin
    busy_nxt  = busy_r;
    cnt_x_nxt = cnt_x_r;
    cnt_y_nxt = cnt_y_r;
    cnt_z_nxt = cnt_z_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_x_nxt = '0;
      cnt_y_nxt = '0;
      cnt_z_nxt = '0;
    end else if (busy_r) begin
      if (!x_last) begin
        cnt_x_nxt = cnt_x_r + XW'(1);
      end else begin
        cnt_x_nxt = '0;
        if (!y_last) begin
          cnt_y_nxt = cnt_y_r + YW'(1);
        end else begin
          cnt_y_nxt = '0;
          if (!z_last) begin
            cnt_z_nxt = cnt_z_r + ZW'(1);
          end else begin
            busy_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_x_r <= cnt_x_nxt;
    cnt_y_r <= cnt_y_nxt;
    cnt_z_r <= cnt_z_nxt;
    if (start) begin
      org_x_r <= crd_x;
      org_y_r <= crd_y;
      org_z_r <= crd_z;
      len_x_r <= len_x;
      len_y_r <= len_y;
      len_z_r <= len_z;
    end
  end

endmodule

// File: hw/rtl/tbg_window.sv
`timescale 1ns / 1ps

module tbg_window import tbg_pkg::*; #(
  parameter int DIM_X = 16,
  parameter int DIM_Y = 16,
  parameter int DIM_Z = 16
) (
  input  logic signed [31:0] cell_x,
  input  logic signed [31:0] cell_y,
  input  logic signed [31:0] cell_z,
  input  logic signed [31:0] min_x,
  input  logic signed [31:0] min_y,
  input  logic signed [31:0] min_z,
  input  logic [EXT_W-1:0]   ext_x,
  input  logic [EXT_W-1:0]   ext_y,
  input  logic [EXT_W-1:0]   ext_z,
  output logic               in_win
);

  // Exact 33-bit offset from the window corner, against the extent
  // saturated to the grid size.
  function automatic logic axis_in(logic [31:0] c, logic [31:0] m,
                                   logic [EXT_W-1:0] e, int dim);
    logic [32:0] rel;
    logic [15:0] es;
    rel = {c[31], c} - {m[31], m};
    es  = (16'(e) > 16'(dim)) ? 16'(dim) : 16'(e);
    return !rel[32] && (rel[31:0] < 32'(es));
  endfunction

  assign in_win = axis_in(cell_x, min_x, ext_x, DIM_X) &&
                  axis_in(cell_y, min_y, ext_y, DIM_Y) &&
                  axis_in(cell_z, min_z, ext_z, DIM_Z);

endmodule

// File: hw/rtl/toroidal_brick_grid_table_core.sv
`timescale 1ns / 1ps

// Toroidal 3D store of 32-bit brick handles in one single-port synchronous
// RAM of DIM_X*DIM_Y*DIM_Z slots. Writes and lookups take one RAM access
// each and are accepted one per cycle while in_stall is low; each result
// is flagged in pend_r and then registered in a two-deep output buffer. A box
// clear sweeps the RAM one slot per cycle over min(box,DIM) product slots;
// a clear-all sweeps all DIM_X*DIM_Y*DIM_Z slots. The result of either
// clear follows its last sweep slot through pend_r and the output buffer.
// A box with any size of zero clears nothing but still gives a result.
// After reset the block runs a clearing pass over all slots with in_stall
// high; register writes are taken during that pass.
module toroidal_brick_grid_table_core import tbg_pkg::*; #(
  parameter int DIM_X = 16,
  parameter int DIM_Y = 16,
  parameter int DIM_Z = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_req_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_res_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SLOTS = DIM_X * DIM_Y * DIM_Z;
  localparam int XB    = $clog2(DIM_X);
  localparam int YB    = $clog2(DIM_Y);
  localparam int ZB    = $clog2(DIM_Z);
  localparam int XW    = (XB > 0) ? XB : 1;
  localparam int YW    = (YB > 0) ? YB : 1;
  localparam int ZW    = (ZB > 0) ? ZB : 1;
  localparam int LXW   = $clog2(DIM_X + 1);
  localparam int LYW   = $clog2(DIM_Y + 1);
  localparam int LZW   = $clog2(DIM_Z + 1);
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Configuration registers.
  logic signed [31:0] win_min_x_r, win_min_y_r, win_min_z_r;
  logic [EXT_W-1:0]   win_ext_x_r, win_ext_y_r, win_ext_z_r;
  logic [31:0]        empty_value_r;
  logic               cfg_we;
  logic [2:0]         cfg_idx;

  // Control.
  state_t      state_r, state_nxt;
  logic        pend_r, pend_nxt;
  logic        pend_in_r, pend_in_nxt;
  logic        post_r, post_nxt;
  logic [31:0] sdata_r, sdata_nxt;
  logic        accept, pop, room;
  logic [1:0]  occ;

  // Output buffer.
  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  out_res_t    out_data_r, out_data_nxt;
  out_res_t    skid_data_r, skid_data_nxt;
  out_res_t    res;

  // Datapath.
  logic           start, sw_full, box_zero, win_inside;
  logic           ram_we;
  logic [31:0]    ram_wdata, ram_rdata;
  logic [AW-1:0]  ram_addr;
  logic [XW-1:0]  crd_x;
  logic [YW-1:0]  crd_y;
  logic [ZW-1:0]  crd_z;
  logic [LXW-1:0] len_x;
  logic [LYW-1:0] len_y;
  logic [LZW-1:0] len_z;
  sweep_stat_t    sw_stat;

  // Register port.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_AW-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_min_x_r   <= '0;
      win_min_y_r   <= '0;
      win_min_z_r   <= '0;
      win_ext_x_r   <= '0;
      win_ext_y_r   <= '0;
      win_ext_z_r   <= '0;
      empty_value_r <= EMPTY_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WIN_MIN_X: win_min_x_r   <= pwdata;
        REG_WIN_MIN_Y: win_min_y_r   <= pwdata;
        REG_WIN_MIN_Z: win_min_z_r   <= pwdata;
        REG_WIN_EXT_X: win_ext_x_r   <= pwdata[EXT_W-1:0];
        REG_WIN_EXT_Y: win_ext_y_r   <= pwdata[EXT_W-1:0];
        REG_WIN_EXT_Z: win_ext_z_r   <= pwdata[EXT_W-1:0];
        REG_EMPTY:     empty_value_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIN_MIN_X: prdata = win_min_x_r;
      REG_WIN_MIN_Y: prdata = win_min_y_r;
      REG_WIN_MIN_Z: prdata = win_min_z_r;
      REG_WIN_EXT_X: prdata = 32'(win_ext_x_r);
      REG_WIN_EXT_Y: prdata = 32'(win_ext_y_r);
      REG_WIN_EXT_Z: prdata = 32'(win_ext_z_r);
      REG_EMPTY:     prdata = empty_value_r;
      default:       prdata = '0;
    endcase
  end

  // Window test for lookups.
  tbg_window #(.DIM_X(DIM_X), .DIM_Y(DIM_Y), .DIM_Z(DIM_Z)) u_window (
    .cell_x (in_data.cell_x),
    .cell_y (in_data.cell_y),
    .cell_z (in_data.cell_z),
    .min_x  (win_min_x_r),
    .min_y  (win_min_y_r),
    .min_z  (win_min_z_r),
    .ext_x  (win_ext_x_r),
    .ext_y  (win_ext_y_r),
    .ext_z  (win_ext_z_r),
    .in_win (win_inside)
  );

  // Sweep setup: the whole grid from slot zero, or the box clipped to the grid.
  assign box_zero = (in_data.box_x == '0) || (in_data.box_y == '0) ||
                    (in_data.box_z == '0);

  always_comb begin
    if (sw_full) begin
      crd_x = '0;
      crd_y = '0;
      crd_z = '0;
      len_x = LXW'(DIM_X);
      len_y = LYW'(DIM_Y);
      len_z = LZW'(DIM_Z);
    end else begin
      crd_x = in_data.cell_x[XW-1:0];
      crd_y = in_data.cell_y[YW-1:0];
      crd_z = in_data.cell_z[ZW-1:0];
      len_x = (16'(in_data.box_x) > 16'(DIM_X)) ? LXW'(DIM_X) : LXW'(in_data.box_x);
      len_y = (16'(in_data.box_y) > 16'(DIM_Y)) ? LYW'(DIM_Y) : LYW'(in_data.box_y);
      len_z = (16'(in_data.box_z) > 16'(DIM_Z)) ? LZW'(DIM_Z) : LZW'(in_data.box_z);
    end
  end

  tbg_addr_gen #(.DIM_X(DIM_X), .DIM_Y(DIM_Y), .DIM_Z(DIM_Z)) u_addr_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .crd_x (crd_x),
    .crd_y (crd_y),
    .crd_z (crd_z),
    .len_x (len_x),
    .len_y (len_y),
    .len_z (len_z),
    .stat  (sw_stat),
    .addr  (ram_addr)
  );

  tbg_ram #(.DEPTH(SLOTS)) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .addr    (ram_addr),
    .wdata   (ram_wdata),
    .rdata_r (ram_rdata)
  );

  // A request is taken when idle and the output buffer has a free place
  // for its result, counting results still on the way.
  assign pop      = out_valid_r && !out_stall;
  assign occ      = 2'(out_valid_r) + 2'(skid_valid_r) + 2'(pend_r);
  assign room     = (occ < 2'd2) || ((occ == 2'd2) && pop);
  assign in_stall = !((state_r == ST_IDLE) && room);
  assign accept   = in_valid && !in_stall;

  // Controller: direct accesses in idle, RAM sweeps otherwise.
  always_comb begin
    state_nxt   = state_r;
    start       = 1'b0;
    sw_full     = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = in_data.handle_value;
    pend_nxt    = 1'b0;
    pend_in_nxt = 1'b0;
    post_nxt    = post_r;
    sdata_nxt   = sdata_r;
    case (state_r)
      ST_INIT: begin
        start     = 1'b1;
        sw_full   = 1'b1;
        post_nxt  = 1'b0;
        sdata_nxt = EMPTY_RESET;
        state_nxt = ST_SWEEP;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.command)
            CMD_WRITE: begin
              ram_we   = 1'b1;
              pend_nxt = 1'b1;
            end
            CMD_LOOKUP: begin
              pend_nxt    = 1'b1;
              pend_in_nxt = win_inside;
            end
            CMD_CLEAR_BOX: begin
              if (box_zero) begin
                pend_nxt = 1'b1;
              end else begin
                start     = 1'b1;
                post_nxt  = 1'b1;
                sdata_nxt = empty_value_r;
                state_nxt = ST_SWEEP;
              end
            end
            CMD_CLEAR_ALL: begin
              start     = 1'b1;
              sw_full   = 1'b1;
              post_nxt  = 1'b1;
              sdata_nxt = empty_value_r;
              state_nxt = ST_SWEEP;
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_wdata = sdata_r;
        if (sw_stat.last) begin
          pend_nxt  = post_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      pend_r  <= 1'b0;
      post_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      post_r  <= post_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_in_r <= pend_in_nxt;
    sdata_r   <= sdata_nxt;
  end

  // Result of the request whose RAM access finished last cycle.
  assign res.found_handle  = pend_in_r ? ram_rdata : empty_value_r;
  assign res.inside_window = pend_in_r;

  // Two-deep output buffer: head register plus skid register.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      out_valid_nxt  = skid_valid_r;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end
    if (pend_r) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The skid register is only used behind a full head register.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the head is empty");

  // A result on the way never finds the buffer full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && skid_valid_r) |-> (out_valid_r && !out_stall))
    else $error("output buffer overflow");

  // The RAM sweep runs only in the sweep state, and no request is taken then.
  a_sweep_state: assert property (@(posedge clk) disable iff (!rst_n)
    sw_stat.busy |-> ((state_r == ST_SWEEP) && in_stall))
    else $error("sweep active outside the sweep state");

  // The end of a commanded clear produces its result on the next cycle.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SWEEP) && sw_stat.last && post_r) |=> pend_r)
    else $error("clear finished without a result");

endmodule
